@@ rtl/kpc_pkg.sv @@
// Package for the key press classifier: shared constants, field codes and
// the command struct between the controller and the datapath. No dependencies.
`default_nettype none

package kpc_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int NUM_KEYS       = 3;
    localparam int TIME_W         = 32;
    localparam int CODE_W         = 3;
    localparam int KEY_W          = 2;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 1;

    localparam logic [TIME_W-1:0] LONG_TICKS_RST   = 32'd1000;
    localparam logic [TIME_W-1:0] FILTER_TICKS_RST = 32'd20;

    // input modes
    localparam logic [MODE_W-1:0] MODE_EDGE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RD_MAIN = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RD_SEC  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TICKS = 1'b1;

    // key status codes
    localparam logic [STATUS_W-1:0] ST_PRESSED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG     = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

    typedef struct packed {
        logic load;   // capture the accepted request
        logic calc;   // duration, empty check, FIFO read
        logic exec;   // update key state and pointers, push codes
        logic emit;   // load the output register
    } t_dp_cmd;

endpackage : kpc_pkg

`default_nettype wire

@@ rtl/kpc_datapath.sv @@
// Datapath of the key press classifier: per-key registers, code FIFO memory,
// pointers, configuration registers and output payload. Uses kpc_pkg.
`default_nettype none

module kpc_datapath
    import kpc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  wire  [MODE_W-1:0]     i_mode,
    input  wire  [KEY_W-1:0]      i_key_index,
    input  wire                   i_pin_level,
    input  wire  [TIME_W-1:0]     i_timestamp,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [TIME_W-1:0]     i_cfg_data,
    output logic [CODE_W-1:0]     o_key_code,
    output logic                  o_fifo_empty,
    output logic [STATUS_W-1:0]   o_key_status
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        ptr_next = (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    // captured request
    logic [MODE_W-1:0]   r_mode;
    logic [KEY_W-1:0]    r_key;
    logic                r_level;
    logic [TIME_W-1:0]   r_ts;

    logic [TIME_W-1:0]   r_long;
    logic [TIME_W-1:0]   r_filter;

    logic [TIME_W-1:0]   r_start [NUM_KEYS];
    logic [STATUS_W-1:0] r_state [NUM_KEYS];

    logic [PW-1:0]       r_wptr;
    logic [PW-1:0]       r_mptr;
    logic [PW-1:0]       r_sptr;

    logic [CODE_W-1:0]   r_mem [FIFO_DEPTH];
    logic [CODE_W-1:0]   r_rd_code;
    logic                r_empty;
    logic [TIME_W-1:0]   r_dur;

    logic [CODE_W-1:0]   r_out_code;
    logic                r_out_empty;
    logic [STATUS_W-1:0] r_out_status;

    logic                key_ok;
    logic [TIME_W-1:0]   start_sel;
    logic [PW-1:0]       rd_ptr;
    logic                is_read;
    logic                is_edge;
    logic                dur_long;
    logic                dur_short;
    logic                push;
    logic [CODE_W-1:0]   push_code;

    assign key_ok    = (r_key < KEY_W'(NUM_KEYS));
    assign start_sel = key_ok ? r_start[r_key] : '0;
    assign rd_ptr    = (r_mode == MODE_RD_MAIN) ? r_mptr : r_sptr;
    assign is_read   = (r_mode == MODE_RD_MAIN) || (r_mode == MODE_RD_SEC);
    assign is_edge   = (r_mode == MODE_EDGE) && key_ok;
    assign dur_long  = (r_dur > r_long);
    assign dur_short = (r_dur > r_filter);
    assign push      = i_cmd.exec && is_edge && r_level && (dur_long || dur_short);
    assign push_code = dur_long ? ({r_key, 1'b0} + CODE_W'(2))
                                : ({r_key, 1'b0} + CODE_W'(1));

    // request capture and per-step scratch values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_key   <= i_key_index;
            r_level <= i_pin_level;
            r_ts    <= i_timestamp;
        end
        if (i_cmd.calc) begin
            r_dur   <= r_ts - start_sel;
            r_empty <= (rd_ptr == r_wptr);
        end
    end

    // code memory
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= push_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_rd_code <= r_mem[rd_ptr];
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long   <= LONG_TICKS_RST;
            r_filter <= FILTER_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LONG_TICKS:   r_long   <= i_cfg_data;
                CFG_FILTER_TICKS: r_filter <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // key state and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_start[k] <= '0;
                r_state[k] <= ST_RELEASED;
            end
            r_wptr <= '0;
            r_mptr <= '0;
            r_sptr <= '0;
        end else if (i_cmd.exec) begin
            if (is_edge) begin
                if (r_level) begin
                    r_state[r_key] <= dur_long ? ST_LONG : ST_RELEASED;
                end else begin
                    r_state[r_key] <= ST_PRESSED;
                    r_start[r_key] <= r_ts;
                end
            end
            if (push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            unique case (r_mode)
                MODE_RD_MAIN: if (!r_empty) r_mptr <= ptr_next(r_mptr);
                MODE_RD_SEC:  if (!r_empty) r_sptr <= ptr_next(r_sptr);
                MODE_CLEAR:   r_mptr <= r_wptr;
                default:      ;
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_code   <= (is_read && !r_empty) ? r_rd_code : CODE_NONE;
            r_out_empty  <= is_read && r_empty;
            r_out_status <= key_ok ? r_state[r_key] : ST_PRESSED;
        end
    end

    assign o_key_code   = r_out_code;
    assign o_fifo_empty = r_out_empty;
    assign o_key_status = r_out_status;

endmodule : kpc_datapath

`default_nettype wire

@@ rtl/kpc_ctrl.sv @@
// Controller of the key press classifier: sequences one request through the
// datapath and owns both handshakes. Uses kpc_pkg.
`default_nettype none

module kpc_ctrl
    import kpc_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CALC = 4'b0010,
        S_EXEC = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                // hold until the output register can take the result
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule : kpc_ctrl

`default_nettype wire

@@ rtl/key_press_classifier_fifo.sv @@
// Key press classifier with code FIFO. The controller takes one request at a
// time through the capture/duration/update/output sequence and accepts the
// next request only after that sequence ends; a stalled output holds it in
// the output step. A new request is taken while a result waits.
// Reset (synchronous, active low): pointers and start times zero, all keys
// released, thresholds 1000 and 20; the code memory is not cleared.
`default_nettype none

module key_press_classifier_fifo
    import kpc_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire  [MODE_W-1:0]     i_mode,
    input  wire  [KEY_W-1:0]      i_key_index,
    input  wire                   i_pin_level,
    input  wire  [TIME_W-1:0]     i_timestamp,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [CODE_W-1:0]     o_key_code,
    output logic                  o_fifo_empty,
    output logic [STATUS_W-1:0]   o_key_status,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [TIME_W-1:0]     i_cfg_data
);

    t_dp_cmd cmd;

    kpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    kpc_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_key_index  (i_key_index),
        .i_pin_level  (i_pin_level),
        .i_timestamp  (i_timestamp),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_key_code   (o_key_code),
        .o_fifo_empty (o_fifo_empty),
        .o_key_status (o_key_status)
    );

endmodule : key_press_classifier_fifo

`default_nettype wire

@@ test/kpc_scoreboard_pkg.sv @@
// Scoreboard for the key press classifier testbench: predicts the answer to
// every accepted request and checks the answers in order. Depends on kpc_pkg.
package kpc_scoreboard_pkg;

    import kpc_pkg::*;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic                empty;
        logic [STATUS_W-1:0] status;
    } t_key_answer;

    localparam int MAX_REPORTS = 10;

    class key_press_scoreboard;
        logic [TIME_W-1:0]   long_ticks;
        logic [TIME_W-1:0]   filter_ticks;
        logic [CODE_W-1:0]   code_mem [FIFO_DEPTH_DEF];
        int                  wr_ptr;
        int                  main_ptr;
        int                  sec_ptr;
        logic [TIME_W-1:0]   press_start [NUM_KEYS];
        logic [STATUS_W-1:0] key_status [NUM_KEYS];
        t_key_answer         answers_due [$];

        int requests;
        int answers;
        int mismatches;
        int short_codes;
        int long_codes;
        int empty_reads;
        int overruns;

        function new();
            long_ticks   = LONG_TICKS_RST;
            filter_ticks = FILTER_TICKS_RST;
            wr_ptr       = 0;
            main_ptr     = 0;
            sec_ptr      = 0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                press_start[k] = '0;
                key_status[k]  = ST_RELEASED;
            end
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
            if (idx == CFG_LONG_TICKS)
                long_ticks = value;
            else
                filter_ticks = value;
        endfunction

        function void push_code(logic [CODE_W-1:0] code);
            code_mem[wr_ptr] = code;
            wr_ptr = (wr_ptr + 1) % FIFO_DEPTH_DEF;
            // writer landed on a reader: everything that reader had is lost
            if (wr_ptr == main_ptr || wr_ptr == sec_ptr)
                overruns++;
        endfunction

        function void read_code(inout int ptr, output logic [CODE_W-1:0] code,
                                output logic empty);
            if (ptr == wr_ptr) begin
                code  = CODE_NONE;
                empty = 1'b1;
                empty_reads++;
            end else begin
                code  = code_mem[ptr];
                empty = 1'b0;
                ptr   = (ptr + 1) % FIFO_DEPTH_DEF;
            end
        endfunction

        function void take_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                   logic level, logic [TIME_W-1:0] ts);
            t_key_answer       ans;
            logic [TIME_W-1:0] held;
            ans.code  = CODE_NONE;
            ans.empty = 1'b0;
            requests++;
            case (mode)
                MODE_EDGE: begin
                    if (key < NUM_KEYS) begin
                        if (level) begin
                            key_status[key] = ST_RELEASED;
                            held = ts - press_start[key];
                            if (held > long_ticks) begin
                                key_status[key] = ST_LONG;
                                push_code(CODE_W'(2 * key + 2));
                                long_codes++;
                            end else if (held > filter_ticks) begin
                                push_code(CODE_W'(2 * key + 1));
                                short_codes++;
                            end
                        end else begin
                            key_status[key]  = ST_PRESSED;
                            press_start[key] = ts;
                        end
                    end
                end
                MODE_RD_MAIN: read_code(main_ptr, ans.code, ans.empty);
                MODE_RD_SEC:  read_code(sec_ptr, ans.code, ans.empty);
                default:      main_ptr = wr_ptr;
            endcase
            // key three has no status and answers zero
            ans.status = (key < NUM_KEYS) ? key_status[key] : ST_PRESSED;
            answers_due.push_back(ans);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] answer %0d: %s", $realtime, answers, what);
        endfunction

        function void check_answer(logic [CODE_W-1:0] code, logic empty,
                                   logic [STATUS_W-1:0] status);
            t_key_answer ans;
            answers++;
            if (answers_due.size() == 0) begin
                report($sformatf("no request outstanding, got code %0d empty %0d status %0d",
                                 code, empty, status));
                return;
            end
            ans = answers_due.pop_front();
            if (code !== ans.code || empty !== ans.empty || status !== ans.status)
                report($sformatf("expected code %0d empty %0d status %0d, got %0d %0d %0d",
                                 ans.code, ans.empty, ans.status, code, empty, status));
        endfunction
    endclass

endpackage : kpc_scoreboard_pkg

@@ test/tb.sv @@
// Testbench for key_press_classifier_fifo: directed and random requests under
// varied handshake pressure and thresholds. Depends on kpc_pkg and kpc_scoreboard_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kpc_pkg::*;
    import kpc_scoreboard_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 200;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [MODE_W-1:0]    i_mode;
    logic [KEY_W-1:0]     i_key_index;
    logic                 i_pin_level;
    logic [TIME_W-1:0]    i_timestamp;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CODE_W-1:0]    o_key_code;
    logic                 o_fifo_empty;
    logic [STATUS_W-1:0]  o_key_status;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [TIME_W-1:0]    i_cfg_data;

    key_press_scoreboard sb = new();

    int sender_idle_pct;
    int receiver_stall_pct;
    int stalled_cycles;

    bit                key_down [NUM_KEYS];
    logic [TIME_W-1:0] press_at [NUM_KEYS];

    key_press_classifier_fifo DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_key_index  (i_key_index),
        .i_pin_level  (i_pin_level),
        .i_timestamp  (i_timestamp),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_key_code   (o_key_code),
        .o_fifo_empty (o_fifo_empty),
        .o_key_status (o_key_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver side: stall at the rate of the current phase
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watch both channels, feed the scoreboard and guard against a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.take_request(i_mode, i_key_index, i_pin_level, i_timestamp);
            if (o_out_valid && i_out_ready)
                sb.check_answer(o_key_code, o_fifo_empty, o_key_status);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                                input logic level, input logic [TIME_W-1:0] ts);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_mode      <= mode;
        i_key_index <= key;
        i_pin_level <= level;
        i_timestamp <= ts;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold requests until every answer is back, then let the block settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.answers_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [TIME_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_threshold(idx, value);
    endtask

    // press length aimed at the threshold edges half of the time
    function automatic logic [TIME_W-1:0] pick_hold();
        case ($urandom_range(7))
            0:       return sb.filter_ticks;
            1:       return sb.filter_ticks + 1;
            2:       return sb.long_ticks;
            3:       return sb.long_ticks + 1;
            4:       return '0;
            5:       return TIME_W'($urandom_range(2000));
            6:       return sb.filter_ticks + $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(input int read_pct);
        int                pick;
        int                key;
        logic [TIME_W-1:0] ts;
        logic              level;
        pick  = $urandom_range(99);
        key   = $urandom_range(NUM_KEYS - 1);
        ts    = $urandom;
        level = 1'($urandom);
        if (pick < read_pct) begin
            send_request(MODE_RD_MAIN, KEY_W'($urandom_range(3)), level, ts);
        end else if (pick < 2 * read_pct) begin
            send_request(MODE_RD_SEC, KEY_W'($urandom_range(3)), level, ts);
        end else if (pick < 2 * read_pct + 4) begin
            send_request(MODE_CLEAR, KEY_W'($urandom_range(3)), level, ts);
        end else if (pick < 2 * read_pct + 10) begin
            // stray edge: key three, double press or release without press
            key = $urandom_range(3);
            send_request(MODE_EDGE, KEY_W'(key), level, ts);
            if (key < NUM_KEYS) begin
                key_down[key] = !level;
                if (!level)
                    press_at[key] = ts;
            end
        end else if (!key_down[key]) begin
            send_request(MODE_EDGE, KEY_W'(key), 1'b0, ts);
            key_down[key] = 1'b1;
            press_at[key] = ts;
        end else begin
            send_request(MODE_EDGE, KEY_W'(key), 1'b1, press_at[key] + pick_hold());
            key_down[key] = 1'b0;
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int read_pct,
                             input logic [TIME_W-1:0] long_v,
                             input logic [TIME_W-1:0] filter_v);
        wait_drained();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        write_threshold(CFG_LONG_TICKS, long_v);
        write_threshold(CFG_FILTER_TICKS, filter_v);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            random_request(read_pct);
            if (i == PHASE_ITEMS / 2)
                wait_drained();
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_mode             = MODE_EDGE;
        i_key_index        = '0;
        i_pin_level        = 1'b0;
        i_timestamp        = '0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_LONG_TICKS;
        i_cfg_data         = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        stalled_cycles     = 0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_down[k] = 1'b0;
            press_at[k] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset thresholds of 1000 and 20
        send_request(MODE_RD_MAIN, 2'd0, 1'b0, 32'h0);
        send_request(MODE_RD_SEC,  2'd3, 1'b1, 32'hFFFF_FFFF);
        send_request(MODE_CLEAR,   2'd2, 1'b1, 32'hFFFF_FFFF);
        send_request(MODE_EDGE,    2'd3, 1'b0, 32'h0);
        send_request(MODE_EDGE,    2'd3, 1'b1, 32'hFFFF_FFFF);
        // press across the timer wrap, 21 ticks: short
        send_request(MODE_EDGE,    2'd0, 1'b0, 32'hFFFF_FFF0);
        send_request(MODE_EDGE,    2'd0, 1'b1, 32'h0000_0005);
        send_request(MODE_EDGE,    2'd1, 1'b0, 32'd100);
        send_request(MODE_EDGE,    2'd1, 1'b1, 32'd1101);
        // exactly the filter length: dropped; then a release without press
        send_request(MODE_EDGE,    2'd2, 1'b0, 32'd500);
        send_request(MODE_EDGE,    2'd2, 1'b1, 32'd520);
        send_request(MODE_EDGE,    2'd2, 1'b1, 32'd521);
        // exactly the long length: short
        send_request(MODE_EDGE,    2'd1, 1'b0, 32'd0);
        send_request(MODE_EDGE,    2'd1, 1'b1, 32'd1000);
        send_request(MODE_EDGE,    2'd1, 1'b1, 32'd1001);
        repeat (5) send_request(MODE_RD_MAIN, 2'd1, 1'b0, 32'h5555_5555);
        repeat (2) send_request(MODE_RD_SEC,  2'd2, 1'b1, 32'hAAAA_AAAA);
        // clear leaves the second reader where it is
        send_request(MODE_CLEAR,   2'd0, 1'b0, 32'h0);
        send_request(MODE_RD_MAIN, 2'd0, 1'b0, 32'h0);
        send_request(MODE_RD_SEC,  2'd1, 1'b0, 32'h0);

        // few reads in the first phase so the writer laps the readers
        run_phase(0,  0,  10, 32'd300,        32'd10);
        run_phase(87, 0,  25, 32'hFFFF_FFFF,  32'd0);
        run_phase(0,  87, 25, 32'd0,          32'hFFFF_FFFF);
        run_phase(6,  6,  25, TIME_W'($urandom_range(3000, 50)),
                  TIME_W'($urandom_range(100)));
        wait_drained();

        $display("%0d requests, %0d answers: %0d short and %0d long codes pushed",
                 sb.requests, sb.answers, sb.short_codes, sb.long_codes);
        $display("%0d reads found the FIFO empty, writer lapped a reader %0d times",
                 sb.empty_reads, sb.overruns);
        if (sb.mismatches == 0 && sb.answers_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d answers missing",
                     sb.mismatches, sb.answers_due.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule : tb
